// ===== rtl/pfx_pkg.sv =====
// Shared types and constants of the postfix expression evaluator.
// No dependencies; used by postfix_expression_evaluator.
package pfx_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } pfx_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } pfx_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV,
    S_DIV_END,
    S_FINISH
  } pfx_state_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = VAL_MAX;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = VAL_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/pfx_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pfx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/postfix_expression_evaluator.sv =====
// Postfix evaluator, one item at a time: a digit goes to S_FINISH, + and - via S_READ,
// * via S_MUL, a divide (Q16.16 by default) via the one-bit-per-cycle restoring divider.
// A last character stays in the final state only while the previous result still waits.
// rst_n (synchronous, active low) clears the stack count, the status and the handshakes.
// The operand stack memory is not cleared; entries are read only after they are written.
// Depends on pfx_pkg and pfx_ram.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfx_pkg::pfx_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pfx_pkg::pfx_out_t out_data
);

  import pfx_pkg::*;

  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int QW  = 33 + FRAC_BITS;
  localparam int NW  = $clog2(QW);
  localparam logic signed [63:0] MBIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  pfx_state_t         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [1:0]         err_r, err_nxt;
  logic signed [31:0] top_r, top_nxt;
  logic [7:0]         char_r, char_nxt;
  logic               last_r, last_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [32:0]        rem_r, rem_nxt;
  logic [QW-1:0]      dvd_r, dvd_nxt;
  logic [31:0]        dvs_r, dvs_nxt;
  logic               neg_r, neg_nxt;
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  pfx_out_t           out_data_r, out_data_nxt;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [31:0]        wdata;
  logic               re;
  logic [31:0]        rdata;

  logic               in_xfer;
  logic               in_digit;
  logic [CW-1:0]      below_idx;
  logic signed [31:0] b_s;
  logic signed [31:0] t_s;
  logic signed [63:0] digit_val;
  logic signed [63:0] sum_val;
  logic signed [63:0] diff_val;
  logic signed [63:0] mul_shift;
  logic [31:0]        b_mag;
  logic [31:0]        t_mag;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic               q_pos_ovf;
  logic               q_neg_ovf;
  logic               out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign in_digit  = (in_data.char_code >= CH_ZERO) && (in_data.char_code <= CH_NINE);
  assign below_idx = count_r - CW'(2);
  assign b_s       = rdata;
  assign t_s       = top_r;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign digit_val = 64'(in_data.char_code - CH_ZERO) << FRAC_BITS;
  assign sum_val   = 64'(b_s) + 64'(t_s);
  assign diff_val  = 64'(b_s) - 64'(t_s);
  // Adding the bias before the arithmetic shift rounds negative products toward zero.
  assign mul_shift = (prod_r + (prod_r[63] ? MBIAS : 64'sd0)) >>> FRAC_BITS;
  assign b_mag     = b_s[31] ? (32'd0 - rdata) : rdata;
  assign t_mag     = t_s[31] ? (32'd0 - top_r) : top_r;

  // One restoring divide step; the quotient bits shift in behind the dividend.
  assign rem_sh    = {rem_r[31:0], dvd_r[QW-1]};
  assign rem_ge    = rem_sh >= {1'b0, dvs_r};
  assign q_pos_ovf = |dvd_r[QW-1:31];
  assign q_neg_ovf = (|dvd_r[QW-1:32]) || (dvd_r[31] && (|dvd_r[30:0]));

  pfx_ram #(
    .WIDTH(32),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(below_idx[AW-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_digit || count_r < CW'(2)) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        case (char_r) inside
          CH_PLUS, CH_MINUS: state_nxt = S_FINISH;
          CH_STAR:           state_nxt = S_MUL;
          default: begin
            if (top_r == 32'sd0) begin
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_MUL:     state_nxt = S_FINISH;
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_DIV_END;
        end
      end
      S_DIV_END: state_nxt = S_FINISH;
      S_FINISH: begin
        if (!last_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    err_nxt       = err_r;
    top_nxt       = top_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    dvs_nxt       = dvs_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we            = 1'b0;
    waddr         = below_idx[AW-1:0];
    wdata         = top_r;
    re            = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          char_nxt = in_data.char_code;
          last_nxt = in_data.last_char;
          if (in_digit) begin
            if (count_r >= CW'(STACK_DEPTH)) begin
              if (err_r == ST_OK) err_nxt = ST_OVER;
            end else begin
              we        = 1'b1;
              waddr     = count_r[AW-1:0];
              wdata     = sat32(digit_val);
              top_nxt   = sat32(digit_val);
              count_nxt = count_r + CW'(1);
            end
          end else if (count_r < CW'(2)) begin
            if (err_r == ST_OK) err_nxt = ST_UNDER;
          end else begin
            re = 1'b1;
          end
        end
      end
      S_READ: begin
        case (char_r) inside
          CH_PLUS, CH_MINUS: begin
            we        = 1'b1;
            wdata     = (char_r == CH_PLUS) ? sat32(sum_val) : sat32(diff_val);
            top_nxt   = wdata;
            count_nxt = count_r - CW'(1);
          end
          CH_STAR: begin
            prod_nxt = b_s * t_s;
          end
          default: begin
            if (top_r == 32'sd0) begin
              we        = 1'b1;
              wdata     = b_s[31] ? VAL_MIN : VAL_MAX;
              top_nxt   = wdata;
              count_nxt = count_r - CW'(1);
              if (err_r == ST_OK) err_nxt = ST_DIVZ;
            end else begin
              rem_nxt = '0;
              dvd_nxt = QW'(b_mag) << FRAC_BITS;
              dvs_nxt = t_mag;
              neg_nxt = b_s[31] ^ t_s[31];
              cnt_nxt = NW'(QW - 1);
            end
          end
        endcase
      end
      S_MUL: begin
        we        = 1'b1;
        wdata     = sat32(mul_shift);
        top_nxt   = wdata;
        count_nxt = count_r - CW'(1);
      end
      S_DIV: begin
        rem_nxt = rem_ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
        dvd_nxt = {dvd_r[QW-2:0], rem_ge};
        cnt_nxt = cnt_r - NW'(1);
      end
      S_DIV_END: begin
        we = 1'b1;
        if (neg_r) begin
          wdata = q_neg_ovf ? VAL_MIN : (32'd0 - dvd_r[31:0]);
        end else begin
          wdata = q_pos_ovf ? VAL_MAX : dvd_r[31:0];
        end
        top_nxt   = wdata;
        count_nxt = count_r - CW'(1);
      end
      S_FINISH: begin
        if (last_r && out_free) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.value  = (count_r != '0) ? top_r : 32'sd0;
          out_data_nxt.status = err_r;
          count_nxt           = '0;
          err_nxt             = ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r      <= top_nxt;
    char_r     <= char_nxt;
    last_r     <= last_nxt;
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    dvs_r      <= dvs_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
